/* hdl/sbm_pkg.sv */
// Shared types and constants for the segmented bank mapper.
package sbm_pkg;

  // Access kinds on the input channel.
  typedef enum logic [1:0] {
    CMD_MEM_RD = 2'd0,
    CMD_MEM_WR = 2'd1,
    CMD_IO_RD  = 2'd2,
    CMD_IO_WR  = 2'd3
  } sbm_cmd_t;

  // Where an access ends up.
  typedef enum logic [2:0] {
    TGT_RAM      = 3'd0,
    TGT_ROM      = 3'd1,
    TGT_EXT      = 3'd2,
    TGT_UNMAPPED = 3'd3,
    TGT_REG      = 3'd4
  } sbm_target_t;

  // Mapper register selector for a register write.
  typedef enum logic [2:0] {
    REG_RAM0   = 3'd0,
    REG_RAM1   = 3'd1,
    REG_RAM2   = 3'd2,
    REG_MAIN   = 3'd3,
    REG_ROM2   = 3'd4,
    REG_DISP   = 3'd5,
    REG_COMPAT = 3'd6
  } sbm_reg_sel_t;

  // The seven mapper registers.
  typedef struct packed {
    logic [7:0] ram0_segment;
    logic [7:0] ram1_segment;
    logic [7:0] ram2_segment;
    logic [7:0] main_page;
    logic [7:0] compat_page;
    logic [7:0] rom2_segment;
    logic [7:0] dispatcher;
  } sbm_regs_t;

  // Register write request from the decoder to the register file.
  typedef struct packed {
    logic         en;
    sbm_reg_sel_t sel;
    logic [7:0]   data;
  } sbm_wr_t;

  // I/O port numbers of the mapper registers and the ID byte.
  localparam logic [7:0] PORT_ID     = 8'h00;
  localparam logic [7:0] PORT_RAM0   = 8'h04;
  localparam logic [7:0] PORT_RAM1   = 8'h05;
  localparam logic [7:0] PORT_RAM2   = 8'h06;
  localparam logic [7:0] PORT_MAIN   = 8'h08;
  localparam logic [7:0] PORT_ROM2   = 8'h09;
  localparam logic [7:0] PORT_DISP   = 8'h0a;
  localparam logic [7:0] PORT_COMPAT = 8'hf9;

  // Full I/O addresses that reach external devices.
  localparam logic [15:0] IO_EXT_FFFD = 16'hfffd;
  localparam logic [15:0] IO_EXT_BFFD = 16'hbffd;
  localparam logic [15:0] IO_EXT_BEFD = 16'hbefd;

  // Dispatcher bit positions.
  localparam int DISP_RAM0   = 0;
  localparam int DISP_RAM1   = 1;
  localparam int DISP_RAM2   = 2;
  localparam int DISP_ROM2   = 3;
  localparam int DISP_ROM1   = 4;
  localparam int DISP_FIXF0  = 6;
  localparam int DISP_COMPAT = 7;

  localparam logic [7:0]  ID_VALUE   = 8'h56;
  localparam logic [7:0]  DISP_RESET = 8'h50;
  localparam logic [7:0]  RDATA_NONE = 8'hff;
  localparam logic [18:0] ROM1_BASE  = 19'h20000;
  localparam logic [18:0] ROM2_BASE  = 19'h22000;

endpackage

/* hdl/sbm_cmod.sv */
// Remainder of a byte by a fixed modulus, via a reciprocal multiply and one correction.
module sbm_cmod #(
  parameter int MOD = 8
) (
  input  logic [7:0]                   val,
  output logic [$clog2(MOD)-1:0]       rem
);

  localparam int RW    = $clog2(MOD);
  localparam int RECIP = (65536 + MOD - 1) / MOD;

  logic [24:0] prod;
  logic [7:0]  quo;
  logic [8:0]  qm;
  logic [8:0]  rem_raw;
  logic [8:0]  rem_fix;

  // Quotient estimate from the scaled reciprocal.
  assign prod    = 25'(val) * 25'(RECIP);
  assign quo     = prod[23:16];
  assign qm      = 9'(quo) * 9'(MOD);
  assign rem_raw = {1'b0, val} - qm;

  // One compare and subtract keeps the remainder below the modulus.
  always_comb begin
    rem_fix = rem_raw;
    if (rem_raw >= 9'(MOD)) begin
      rem_fix = rem_raw - 9'(MOD);
    end
  end

  assign rem = rem_fix[RW-1:0];

endmodule

/* hdl/sbm_xlate.sv */
// Address translation and I/O decode for one access against the current mapper registers.
module sbm_xlate #(
  parameter int PAGE_COUNT    = 8,
  parameter int SEGMENT_COUNT = 32
) (
  input  sbm_pkg::sbm_cmd_t    cmd,
  input  logic [15:0]          addr,
  input  logic [7:0]           wdata,
  input  sbm_pkg::sbm_regs_t   regs,
  output sbm_pkg::sbm_target_t target,
  output logic [18:0]          phys_addr,
  output logic [7:0]           rdata,
  output sbm_pkg::sbm_wr_t     wr
);

  import sbm_pkg::*;

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int SW = $clog2(SEGMENT_COUNT);

  logic [7:0]    page_raw;
  logic [PW-1:0] page;
  logic [SW-1:0] seg0;
  logic [SW-1:0] seg1;
  logic [SW-1:0] seg2;
  logic [18:0]   paged;
  logic [18:0]   seg0_addr;
  logic [18:0]   seg1_addr;
  logic [18:0]   seg2_addr;
  logic [18:0]   rom2_addr;
  logic [18:0]   flat_addr;
  logic [7:0]    hi;
  logic [7:0]    port;
  logic [7:0]    disp;
  logic          mem_wr;

  assign disp   = regs.dispatcher;
  assign hi     = addr[15:8];
  assign port   = addr[7:0];
  assign mem_wr = (cmd == CMD_MEM_WR);

  // Page and segment numbers reduced to the installed counts.
  assign page_raw = disp[DISP_COMPAT] ? regs.compat_page : regs.main_page;

  sbm_cmod #(.MOD(PAGE_COUNT))    u_page_mod (.val(page_raw),          .rem(page));
  sbm_cmod #(.MOD(SEGMENT_COUNT)) u_seg0_mod (.val(regs.ram0_segment), .rem(seg0));
  sbm_cmod #(.MOD(SEGMENT_COUNT)) u_seg1_mod (.val(regs.ram1_segment), .rem(seg1));
  sbm_cmod #(.MOD(SEGMENT_COUNT)) u_seg2_mod (.val(regs.ram2_segment), .rem(seg2));

  // Candidate physical addresses for each kind of window.
  assign paged     = (19'(page) << 16) | 19'(addr);
  assign seg0_addr = (19'(seg0) << 14) | 19'(addr[13:0]);
  assign seg1_addr = (19'(seg1) << 14) | 19'(addr[13:0]);
  assign seg2_addr = (19'(seg2) << 14) | 19'(addr[13:0]);
  assign rom2_addr = ROM2_BASE + (19'(regs.rom2_segment[2:0]) << 13) + 19'(addr[12:0]);
  assign flat_addr = 19'(addr);

  always_comb begin
    target    = TGT_UNMAPPED;
    phys_addr = '0;
    rdata     = RDATA_NONE;
    wr.en     = 1'b0;
    wr.sel    = REG_RAM0;
    wr.data   = wdata;

    unique case (cmd)
      CMD_MEM_RD, CMD_MEM_WR: begin
        target = TGT_RAM;
        if (addr[15:13] == 3'd0) begin
          // Lowest 8 KiB: ROM1, RAM segment 0 or the page.
          if (disp[DISP_ROM1]) begin
            if (mem_wr) begin
              target = TGT_UNMAPPED;
            end else begin
              target    = TGT_ROM;
              phys_addr = ROM1_BASE + flat_addr;
            end
          end else if (disp[DISP_RAM0]) begin
            phys_addr = seg0_addr;
          end else begin
            phys_addr = paged;
          end
        end else if (addr[15:14] == 2'd0) begin
          // Second 8 KiB: banked ROM2, RAM segment 0 or the page.
          if (disp[DISP_ROM2]) begin
            if (mem_wr) begin
              target = TGT_UNMAPPED;
            end else begin
              target    = TGT_ROM;
              phys_addr = rom2_addr;
            end
          end else if (disp[DISP_RAM0]) begin
            phys_addr = seg0_addr;
          end else begin
            phys_addr = paged;
          end
        end else if (addr[15:14] == 2'd1) begin
          phys_addr = disp[DISP_RAM1] ? seg1_addr : paged;
        end else if (addr[15:14] == 2'd2) begin
          phys_addr = disp[DISP_RAM2] ? seg2_addr : paged;
        end else if (addr[15:12] != 4'hf) begin
          phys_addr = paged;
        end else if (!disp[DISP_COMPAT]) begin
          phys_addr = disp[DISP_FIXF0] ? flat_addr : paged;
        end else if (addr[11:10] == 2'd0) begin
          // Compatibility mode, fixed RAM at the bottom of the top 4 KiB.
          phys_addr = flat_addr;
        end else if (!addr[11]) begin
          target = (hi == 8'hf6) ? TGT_UNMAPPED : TGT_EXT;
        end else if (!mem_wr) begin
          phys_addr = flat_addr;
        end else if (hi == PORT_COMPAT) begin
          // A write to the F9xx page updates the compatibility page.
          target = TGT_REG;
          wr.en  = 1'b1;
          wr.sel = REG_COMPAT;
        end else if (hi == 8'hf8 || hi == 8'hfa || hi == 8'hff) begin
          target = TGT_EXT;
        end else begin
          target = TGT_UNMAPPED;
        end
      end

      CMD_IO_RD: begin
        target = TGT_REG;
        unique case (port) inside
          PORT_ID:   rdata = ID_VALUE;
          PORT_RAM0: rdata = regs.ram0_segment;
          PORT_RAM1: rdata = regs.ram1_segment;
          PORT_RAM2: rdata = regs.ram2_segment;
          PORT_MAIN: rdata = regs.main_page;
          PORT_ROM2: rdata = regs.rom2_segment;
          PORT_DISP: rdata = regs.dispatcher;
          [8'h10:8'h13], [8'h18:8'h1b], [8'h28:8'h2b]: target = TGT_EXT;
          default: begin
            target = (addr == IO_EXT_FFFD) ? TGT_EXT : TGT_UNMAPPED;
          end
        endcase
      end

      CMD_IO_WR: begin
        target = TGT_REG;
        unique case (port) inside
          PORT_RAM0: begin
            wr.en  = 1'b1;
            wr.sel = REG_RAM0;
          end
          PORT_RAM1: begin
            wr.en  = 1'b1;
            wr.sel = REG_RAM1;
          end
          PORT_RAM2: begin
            wr.en  = 1'b1;
            wr.sel = REG_RAM2;
          end
          PORT_MAIN: begin
            wr.en  = 1'b1;
            wr.sel = REG_MAIN;
          end
          PORT_ROM2: begin
            wr.en  = 1'b1;
            wr.sel = REG_ROM2;
          end
          PORT_DISP: begin
            wr.en  = 1'b1;
            wr.sel = REG_DISP;
          end
          PORT_COMPAT: begin
            wr.en  = 1'b1;
            wr.sel = REG_COMPAT;
          end
          8'hf8, 8'hfa, 8'hfc, 8'hfe, 8'hff,
          [8'h10:8'h14], [8'h18:8'h1b], [8'h28:8'h2b]: target = TGT_EXT;
          default: begin
            if (addr == IO_EXT_FFFD || addr == IO_EXT_BFFD || addr == IO_EXT_BEFD) begin
              target = TGT_EXT;
            end else begin
              target = TGT_UNMAPPED;
            end
          end
        endcase
      end

      default: target = TGT_UNMAPPED;
    endcase
  end

endmodule

/* hdl/segmented_bank_mapper_with_ports.sv */
// Top level of the segmented bank mapper: stream ports, mapper registers and pipeline.
//
// Each transaction on the in_ channel is one CPU access (memory or I/O, read or
// write). Each produces exactly one transaction on the out_ channel carrying the
// target (RAM, ROM, external device, unmapped or mapper register), the
// physical RAM address or ROM offset, and the byte read from a mapper register.
// I/O writes to the mapper ports and writes to the F9xx window in compatibility mode update the
// mapper registers; the new mapping applies from the next access on.
// An accepted access is held in an input register; the translation runs
// combinationally from there into the output register, which drives out_tvalid.
// Throughput is one access per cycle while the receiver keeps out_tready high,
// set by that single register-to-register translation path.
// When the receiver holds out_tready low, the result stays in the output
// register and one further access can wait in the input register; in_tready
// then falls until the output drains.
// Reset (rst_n low, synchronous) empties both registers and restores the mapper
// registers: segments and pages to zero, dispatcher to 0x50.
module segmented_bank_mapper_with_ports #(
  parameter int PAGE_COUNT    = 8,
  parameter int SEGMENT_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [1:0] cmd, [17:2] addr, [25:18] wdata, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [2:0] target, [21:3] phys_addr, [29:22] rdata, rest zero
);

  import sbm_pkg::*;

  logic        s1_vld_r;
  logic [25:0] s1_data_r;
  logic        s1_move;
  logic        out_vld_r;
  logic [29:0] out_data_r;
  sbm_regs_t   regs_r;
  sbm_regs_t   regs_nxt;

  sbm_cmd_t    x_cmd;
  sbm_target_t x_target;
  logic [18:0] x_phys;
  logic [7:0]  x_rdata;
  sbm_wr_t     x_wr;

  // Handshake: the input stage advances when the output register is free or is being read out.
  assign s1_move    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !s1_vld_r || s1_move;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_data_r};

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata[25:0];
    end
  end

  // Translation of the held access.
  assign x_cmd = sbm_cmd_t'(s1_data_r[1:0]);

  sbm_xlate #(
    .PAGE_COUNT   (PAGE_COUNT),
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_xlate (
    .cmd      (x_cmd),
    .addr     (s1_data_r[17:2]),
    .wdata    (s1_data_r[25:18]),
    .regs     (regs_r),
    .target   (x_target),
    .phys_addr(x_phys),
    .rdata    (x_rdata),
    .wr       (x_wr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_move) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= {x_rdata, x_phys, x_target};
    end
  end

  // Mapper register update, committed as the access leaves the input stage.
  always_comb begin
    regs_nxt = regs_r;
    if (s1_move && x_wr.en) begin
      case (x_wr.sel)
        REG_RAM0:   regs_nxt.ram0_segment = x_wr.data;
        REG_RAM1:   regs_nxt.ram1_segment = x_wr.data;
        REG_RAM2:   regs_nxt.ram2_segment = x_wr.data;
        REG_MAIN:   regs_nxt.main_page    = x_wr.data;
        REG_ROM2:   regs_nxt.rom2_segment = x_wr.data;
        REG_DISP:   regs_nxt.dispatcher   = x_wr.data;
        REG_COMPAT: regs_nxt.compat_page  = x_wr.data;
        default:    regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{ram0_segment: 8'h00,
                  ram1_segment: 8'h00,
                  ram2_segment: 8'h00,
                  main_page:    8'h00,
                  compat_page:  8'h00,
                  rom2_segment: 8'h00,
                  dispatcher:   DISP_RESET};
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Only a mapper register access returns data other than 0xff.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r[29:22] != RDATA_NONE) |-> out_data_r[2:0] == TGT_REG)
    else $error("read data on an access that is not a register read");

  // A physical address is only given for RAM and ROM accesses.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r[21:3] != '0) |->
      (out_data_r[2:0] == TGT_RAM) || (out_data_r[2:0] == TGT_ROM))
    else $error("physical address on a non-memory target");

  // The mapper registers change only when an access is committed.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(s1_move) |-> $stable(regs_r))
    else $error("mapper registers changed without a committed access");

  // Reset leaves the dispatcher at its power-on value.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> regs_r.dispatcher == DISP_RESET)
    else $error("dispatcher not at reset value after reset");

endmodule

/* tb/sv/segmented_bank_mapper_with_ports_tb.sv */
// Self-checking testbench for the segmented bank mapper with its stream ports.
module segmented_bank_mapper_with_ports_tb;
  import sbm_pkg::*;

  // Run length, idle rate and watchdog settings.
  localparam int NUM_RANDOM     = 1700;
  localparam int IDLE_PERCENT   = 15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // External device port groups on the I/O bus.
  localparam logic [7:0] EXT_A_LO    = 8'h10;
  localparam logic [7:0] EXT_A_RD_HI = 8'h13;
  localparam logic [7:0] EXT_A_WR_HI = 8'h14;
  localparam logic [7:0] EXT_B_LO    = 8'h18;
  localparam logic [7:0] EXT_B_HI    = 8'h1b;
  localparam logic [7:0] EXT_C_LO    = 8'h28;
  localparam logic [7:0] EXT_C_HI    = 8'h2b;
  localparam logic [7:0] EXT_WR_F8   = 8'hf8;
  localparam logic [7:0] EXT_WR_FA   = 8'hfa;
  localparam logic [7:0] EXT_WR_FC   = 8'hfc;
  localparam logic [7:0] EXT_WR_FE   = 8'hfe;
  localparam logic [7:0] EXT_WR_FF   = 8'hff;

  // One translated access as it leaves the block.
  typedef struct packed {
    sbm_target_t target;
    logic [18:0] phys;
    logic [7:0]  rdata;
  } mapping_t;

  // Scoreboard: predicts each accepted access and checks the results in order.
  class bank_map_scoreboard;
    sbm_regs_t regs;
    mapping_t  pending_q[$];
    int        n_errors;
    int        n_checked;
    int        target_hits[5];

    function new();
      regs = '0;
      regs.dispatcher = DISP_RESET;
      n_errors = 0;
      n_checked = 0;
      foreach (target_hits[i]) target_hits[i] = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Memory access through the eight windows; a compatibility write to F9xx
    // updates the compatibility page.
    function mapping_t translate_memory(bit wr, logic [15:0] a, logic [7:0] d);
      mapping_t    r;
      logic [7:0]  disp;
      logic [2:0]  page;
      logic [18:0] paged;
      logic [7:0]  hi;
      disp  = regs.dispatcher;
      page  = disp[DISP_COMPAT] ? regs.compat_page[2:0] : regs.main_page[2:0];
      paged = {page, a};
      hi    = a[15:8];
      r.target = TGT_RAM;
      r.phys   = '0;
      r.rdata  = RDATA_NONE;
      if (a < 16'h2000) begin
        if (disp[DISP_ROM1]) begin
          if (wr) r.target = TGT_UNMAPPED;
          else begin
            r.target = TGT_ROM;
            r.phys   = ROM1_BASE + a;
          end
        end else if (disp[DISP_RAM0]) r.phys = {regs.ram0_segment[4:0], a[13:0]};
        else r.phys = paged;
      end else if (a < 16'h4000) begin
        if (disp[DISP_ROM2]) begin
          if (wr) r.target = TGT_UNMAPPED;
          else begin
            r.target = TGT_ROM;
            r.phys   = ROM2_BASE + {regs.rom2_segment[2:0], 13'b0} + a[12:0];
          end
        end else if (disp[DISP_RAM0]) r.phys = {regs.ram0_segment[4:0], a[13:0]};
        else r.phys = paged;
      end else if (a < 16'h8000) begin
        r.phys = disp[DISP_RAM1] ? {regs.ram1_segment[4:0], a[13:0]} : paged;
      end else if (a < 16'hc000) begin
        r.phys = disp[DISP_RAM2] ? {regs.ram2_segment[4:0], a[13:0]} : paged;
      end else if (a < 16'hf000) begin
        r.phys = paged;
      end else if (!disp[DISP_COMPAT]) begin
        r.phys = disp[DISP_FIXF0] ? {3'b0, a} : paged;
      end else if (a < 16'hf400) begin
        r.phys = {3'b0, a};
      end else if (a < 16'hf800) begin
        r.target = (hi == 8'hf6) ? TGT_UNMAPPED : TGT_EXT;
      end else if (!wr) begin
        r.phys = {3'b0, a};
      end else if (hi == 8'hf9) begin
        regs.compat_page = d;
        r.target = TGT_REG;
      end else if (hi == 8'hf8 || hi == 8'hfa || hi == 8'hff) begin
        r.target = TGT_EXT;
      end else begin
        r.target = TGT_UNMAPPED;
      end
      return r;
    endfunction

    // I/O read: ID byte, mapper registers, external devices or nothing.
    function mapping_t read_port(logic [15:0] a);
      mapping_t   r;
      logic [7:0] port;
      port = a[7:0];
      r.phys   = '0;
      r.rdata  = RDATA_NONE;
      r.target = TGT_REG;
      case (port)
        PORT_ID:   r.rdata = ID_VALUE;
        PORT_RAM0: r.rdata = regs.ram0_segment;
        PORT_RAM1: r.rdata = regs.ram1_segment;
        PORT_RAM2: r.rdata = regs.ram2_segment;
        PORT_MAIN: r.rdata = regs.main_page;
        PORT_ROM2: r.rdata = regs.rom2_segment;
        PORT_DISP: r.rdata = regs.dispatcher;
        default: begin
          if ((port >= EXT_A_LO && port <= EXT_A_RD_HI) ||
              (port >= EXT_B_LO && port <= EXT_B_HI) ||
              (port >= EXT_C_LO && port <= EXT_C_HI) || a == IO_EXT_FFFD)
            r.target = TGT_EXT;
          else
            r.target = TGT_UNMAPPED;
        end
      endcase
      return r;
    endfunction

    // I/O write: mapper registers, external devices or nothing.
    function mapping_t write_port(logic [15:0] a, logic [7:0] d);
      mapping_t   r;
      logic [7:0] port;
      port = a[7:0];
      r.phys   = '0;
      r.rdata  = RDATA_NONE;
      r.target = TGT_REG;
      case (port)
        PORT_RAM0:   regs.ram0_segment = d;
        PORT_RAM1:   regs.ram1_segment = d;
        PORT_RAM2:   regs.ram2_segment = d;
        PORT_MAIN:   regs.main_page    = d;
        PORT_ROM2:   regs.rom2_segment = d;
        PORT_DISP:   regs.dispatcher   = d;
        PORT_COMPAT: regs.compat_page  = d;
        EXT_WR_F8, EXT_WR_FA, EXT_WR_FC, EXT_WR_FE, EXT_WR_FF: r.target = TGT_EXT;
        default: begin
          if ((port >= EXT_A_LO && port <= EXT_A_WR_HI) ||
              (port >= EXT_B_LO && port <= EXT_B_HI) ||
              (port >= EXT_C_LO && port <= EXT_C_HI) ||
              a == IO_EXT_FFFD || a == IO_EXT_BFFD || a == IO_EXT_BEFD)
            r.target = TGT_EXT;
          else
            r.target = TGT_UNMAPPED;
        end
      endcase
      return r;
    endfunction

    // Called for every accepted input transaction.
    function void note_access(sbm_cmd_t cmd, logic [15:0] a, logic [7:0] d);
      mapping_t r;
      case (cmd)
        CMD_MEM_RD: r = translate_memory(1'b0, a, d);
        CMD_MEM_WR: r = translate_memory(1'b1, a, d);
        CMD_IO_RD:  r = read_port(a);
        default:    r = write_port(a, d);
      endcase
      target_hits[r.target]++;
      pending_q.push_back(r);
    endfunction

    // Called for every accepted output transaction.
    function void check_result(logic [31:0] tdata);
      mapping_t got;
      mapping_t want;
      got.target = sbm_target_t'(tdata[2:0]);
      got.phys   = tdata[21:3];
      got.rdata  = tdata[29:22];
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, got %h", $time, tdata);
        n_errors++;
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      if (got.target !== want.target) begin
        $display("%0t: target mismatch, expected %0d, actual %0d",
                 $time, want.target, got.target);
        n_errors++;
      end
      if (got.phys !== want.phys) begin
        $display("%0t: phys_addr mismatch, expected %h, actual %h",
                 $time, want.phys, got.phys);
        n_errors++;
      end
      if (got.rdata !== want.rdata) begin
        $display("%0t: rdata mismatch, expected %h, actual %h",
                 $time, want.rdata, got.rdata);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  bank_map_scoreboard sb = new();
  bit quiet_stretch = 1'b0;
  int idle_cycles = 0;
  int n_directed = 0;
  int n_random = 0;

  segmented_bank_mapper_with_ports u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random except during the quiet stretch.
  always @(negedge clk) begin
    out_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Monitor both channels; results are checked before the new access is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready)
        sb.note_access(sbm_cmd_t'(in_tdata[1:0]), in_tdata[17:2], in_tdata[25:18]);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one access, with random gaps before it, and hold it until accepted.
  // Called and returning at a falling edge.
  task automatic issue_access(sbm_cmd_t cmd, logic [15:0] a, logic [7:0] d);
    while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, d, a, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic directed_access(sbm_cmd_t cmd, logic [15:0] a, logic [7:0] d);
    issue_access(cmd, a, d);
    n_directed++;
  endtask

  function automatic logic [7:0] mapper_port(int idx);
    case (idx)
      0:       return PORT_RAM0;
      1:       return PORT_RAM1;
      2:       return PORT_RAM2;
      3:       return PORT_MAIN;
      4:       return PORT_ROM2;
      5:       return PORT_DISP;
      6:       return PORT_COMPAT;
      default: return PORT_ID;
    endcase
  endfunction

  // One random access: register writes keep the mapping moving, memory
  // accesses favour the upper window where compatibility mode decodes finely.
  task automatic random_access();
    int         pick;
    logic [15:0] a;
    logic [7:0]  d;
    sbm_cmd_t    cmd;
    pick = $urandom_range(99);
    a    = 16'($urandom);
    d    = 8'($urandom);
    if (pick < 20) begin
      cmd     = CMD_IO_WR;
      a[7:0]  = mapper_port($urandom_range(6));
    end else if (pick < 30) begin
      cmd     = CMD_IO_RD;
      a[7:0]  = mapper_port($urandom_range(7));
      if (a[7:0] == PORT_COMPAT) a[7:0] = PORT_ID;
    end else if (pick < 42) begin
      cmd = $urandom_range(1) ? CMD_IO_WR : CMD_IO_RD;
      case ($urandom_range(3))
        0: a = IO_EXT_FFFD;
        1: a = $urandom_range(1) ? IO_EXT_BFFD : IO_EXT_BEFD;
        2: a[7:0] = 8'($urandom_range(8'h30));
        default: ;
      endcase
    end else begin
      cmd = $urandom_range(1) ? CMD_MEM_WR : CMD_MEM_RD;
      if (pick < 62) a[15:12] = 4'hf;
    end
    issue_access(cmd, a, d);
    n_random++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: ID, dispatcher, ROM1 window and the fixed F000 window.
    directed_access(CMD_IO_RD, 16'h0000, 8'h00);
    directed_access(CMD_IO_RD, {8'h00, PORT_DISP}, 8'h00);
    directed_access(CMD_MEM_RD, 16'h0000, 8'h00);
    directed_access(CMD_MEM_WR, 16'h1fff, 8'hff);
    directed_access(CMD_MEM_RD, 16'hffff, 8'h00);

    // Load every register but the compatibility page, then read back RAM segment 0.
    directed_access(CMD_IO_WR, {8'hff, PORT_MAIN}, 8'hff);
    directed_access(CMD_IO_WR, {8'h00, PORT_RAM0}, 8'hff);
    directed_access(CMD_IO_WR, {8'h12, PORT_RAM1}, 8'h21);
    directed_access(CMD_IO_WR, {8'h00, PORT_RAM2}, 8'h80);
    directed_access(CMD_IO_WR, {8'h00, PORT_ROM2}, 8'hff);
    directed_access(CMD_IO_WR, {8'h00, PORT_DISP}, 8'h0f);
    directed_access(CMD_IO_RD, {8'hff, PORT_RAM0}, 8'h00);

    // Segment windows, the ROM2 window and a write into it, then paged areas.
    directed_access(CMD_MEM_RD, 16'h0000, 8'h00);
    directed_access(CMD_MEM_RD, 16'h2000, 8'h00);
    directed_access(CMD_MEM_WR, 16'h3fff, 8'h55);
    directed_access(CMD_MEM_WR, 16'h4000, 8'haa);
    directed_access(CMD_MEM_RD, 16'hbfff, 8'h00);
    directed_access(CMD_MEM_WR, 16'hf000, 8'h01);

    // Compatibility mode: page write through F9xx, then the fine-grained windows.
    directed_access(CMD_IO_WR, {8'h00, PORT_DISP}, 8'h80);
    directed_access(CMD_MEM_WR, 16'hf9ab, 8'h05);
    directed_access(CMD_MEM_RD, 16'h0000, 8'h00);
    directed_access(CMD_MEM_WR, 16'hf6ff, 8'h00);
    directed_access(CMD_MEM_RD, 16'hf400, 8'h00);
    directed_access(CMD_MEM_WR, 16'hfb00, 8'h00);
    directed_access(CMD_MEM_WR, 16'hffff, 8'h00);

    // External and unmapped I/O, and the compatibility page port.
    directed_access(CMD_IO_RD, IO_EXT_FFFD, 8'h00);
    directed_access(CMD_IO_WR, IO_EXT_BEFD, 8'h00);
    directed_access(CMD_IO_RD, {8'h00, EXT_A_WR_HI}, 8'h00);
    directed_access(CMD_IO_WR, {8'h00, PORT_COMPAT}, 8'hff);

    // Random part, with a stretch in the middle where neither side idles.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet_stretch = (i >= 700 && i < 1000);
      random_access();
    end
    quiet_stretch = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random accesses, %0d results compared.",
             n_directed, n_random, sb.n_checked);
    $display("Targets seen: ram %0d, rom %0d, external %0d, unmapped %0d, register %0d.",
             sb.target_hits[TGT_RAM], sb.target_hits[TGT_ROM], sb.target_hits[TGT_EXT],
             sb.target_hits[TGT_UNMAPPED], sb.target_hits[TGT_REG]);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
